// ===== hdl/wma3_pkg.sv =====
// Shared types and constants for the three-axis weighted moving average.
// No dependencies; imported by every module of the block.
`default_nettype none

package wma3_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int QUOT_W     = 16;
    localparam int AXES       = 3;
    localparam int WINDOW_DEF = 32;

    // Defaults for the quotient unit at the default window
    localparam int TOTAL_DEF  = WINDOW_DEF * (WINDOW_DEF + 1) / 2;
    localparam int ACC_W_DEF  = $clog2(TOTAL_DEF + 1) + QUOT_W + 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x_in;
        logic signed [SAMPLE_W-1:0] y_in;
        logic signed [SAMPLE_W-1:0] z_in;
    } in_item_t;

    typedef struct packed {
        logic signed [QUOT_W-1:0] x_avg;
        logic signed [QUOT_W-1:0] y_avg;
        logic signed [QUOT_W-1:0] z_avg;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_OUTPUT
    } wma3_state_t;

endpackage

`default_nettype wire

// ===== hdl/wma3_div.sv =====
// Signed divide of the weighted sum by the constant total weight, done as a
// reciprocal multiply: magnitude and sign are registered, then the high bits of
// the product. Depends on wma3_pkg. Quotient truncates toward zero.
`default_nettype none

module wma3_div
    import wma3_pkg::*;
#(
    parameter int TOTAL = TOTAL_DEF,
    parameter int ACC_W = ACC_W_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [ACC_W-1:0] dividend,
    output logic                    done,
    output logic [QUOT_W-1:0]       quot
);

    localparam int MAG_W  = ACC_W - 1;
    localparam int RCP_W  = MAG_W + 2;
    localparam int PROD_W = MAG_W + RCP_W;
    localparam int SH     = MAG_W + $clog2(TOTAL);
    // ceil(2^SH / TOTAL): exact floor quotient for every magnitude below 2^MAG_W
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SH) + 64'(TOTAL) - 64'd1) / 64'(TOTAL);
    localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

    logic              start_d_reg;
    logic              done_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic              neg_reg;
    logic [QUOT_W-1:0] q_reg;

    logic [ACC_W-1:0]  neg_dividend;
    logic [ACC_W-1:0]  mag;
    logic [PROD_W-1:0] prod;

    assign neg_dividend = ~dividend + 1'b1;
    assign mag          = dividend[ACC_W-1] ? neg_dividend : dividend;
    assign prod         = {{RCP_W{1'b0}}, mag_reg} * {{MAG_W{1'b0}}, RCP};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_d_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            start_d_reg <= start;
            done_reg    <= start_d_reg;
        end
    end

    // stage 1: magnitude and sign; stage 2: multiply and take the high bits
    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= mag[MAG_W-1:0];
            neg_reg <= dividend[ACC_W-1];
        end
        if (start_d_reg) begin
            q_reg <= prod[SH +: QUOT_W];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

`default_nettype wire

// ===== hdl/weighted_moving_average_3axis_core.sv =====
// Three-axis linearly weighted moving average: top level.
// Depends on wma3_pkg and wma3_div.
//
// Each request carries one x/y/z sample; each gives exactly one result, the
// weighted average of the last WINDOW samples per axis (newest weight WINDOW,
// oldest weight 1, divided by WINDOW*(WINDOW+1)/2, truncated toward zero).
// The history sits in a single-port-read memory with a registered read port,
// cleared logically at reset by per-entry valid bits, so no clearing pass is
// needed. After a request is taken the block walks the history through the
// memory read port one entry per cycle, newest first, accumulating, then runs
// the reciprocal-multiply quotient unit and hands the result into the result
// register. The input reopens once the result is loaded, which waits while an
// earlier result is still unaccepted, so no new request is taken while one is
// in work. One item is processed at a time; the result register lets the next
// request be accepted while the previous result waits.
`default_nettype none

module weighted_moving_average_3axis_core
    import wma3_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int TOTAL = WINDOW * (WINDOW + 1) / 2;
    localparam int TW    = $clog2(TOTAL + 1);
    localparam int ACC_W = TW + QUOT_W + 1;
    localparam int PW    = SAMPLE_W + CW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW - 1);

    wma3_state_t state_reg, state_next;

    logic [AW-1:0]     slot_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     rd_cnt_reg;
    logic              rd_pend_reg;
    logic [CW-1:0]     wt_reg;
    logic [WINDOW-1:0] valid_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    in_item_t          mem [WINDOW];
    in_item_t          rdata_reg;
    logic              rvalid_reg;

    logic signed [ACC_W-1:0]    acc_reg [AXES];
    logic signed [SAMPLE_W-1:0] samp    [AXES];
    logic signed [PW-1:0]       prod    [AXES];
    logic [QUOT_W-1:0]          quot    [AXES];
    logic [AXES-1:0]            done;

    logic take;
    logic rd_en;
    logic acc_en;
    logic div_start;
    logic out_load;
    logic div_done;

    assign div_done = &done;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (rd_cnt_reg == '0 && !rd_pend_reg) state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_done) state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready   = 1'b0;
        rd_en     = 1'b0;
        acc_en    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_ACCUM: begin
                rd_en     = (rd_cnt_reg != '0);
                acc_en    = rd_pend_reg;
                div_start = (rd_cnt_reg == '0) && !rd_pend_reg;
            end
            ST_DIVIDE: begin
            end
            ST_OUTPUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    assign take = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            rd_cnt_reg  <= '0;
            rd_pend_reg <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            if (take) begin
                slot_reg            <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                valid_reg[slot_reg] <= 1'b1;
                rd_cnt_reg          <= CW'(WINDOW);
            end else if (rd_en) begin
                rd_cnt_reg <= rd_cnt_reg - 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // history memory: write at acceptance, read walks from newest to oldest
    always_ff @(posedge aclk) begin
        if (take) begin
            mem[slot_reg] <= s_data;
        end
        if (rd_en) begin
            rdata_reg  <= mem[rd_ptr_reg];
            rvalid_reg <= valid_reg[rd_ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            rd_ptr_reg <= slot_reg;
            wt_reg     <= CW'(WINDOW);
        end else begin
            if (rd_en) begin
                rd_ptr_reg <= (rd_ptr_reg == '0) ? LAST_SLOT : rd_ptr_reg - 1'b1;
            end
            if (acc_en) begin
                wt_reg <= wt_reg - 1'b1;
            end
        end
    end

    // never-written entries read as zero samples
    assign samp[0] = rvalid_reg ? rdata_reg.x_in : '0;
    assign samp[1] = rvalid_reg ? rdata_reg.y_in : '0;
    assign samp[2] = rvalid_reg ? rdata_reg.z_in : '0;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        assign prod[a] = samp[a] * $signed({1'b0, wt_reg});

        always_ff @(posedge aclk) begin
            if (take) begin
                acc_reg[a] <= '0;
            end else if (acc_en) begin
                acc_reg[a] <= acc_reg[a] + ACC_W'(prod[a]);
            end
        end

        wma3_div #(
            .TOTAL (TOTAL),
            .ACC_W (ACC_W)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (acc_reg[a]),
            .done     (done[a]),
            .quot     (quot[a])
        );
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.x_avg <= quot[0];
            m_data_reg.y_avg <= quot[1];
            m_data_reg.z_avg <= quot[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== hdl/wma3_chk.sv =====
// Port-level checks for the weighted moving average core, with the bind
// that attaches them. Depends on wma3_pkg.
`default_nettype none

module wma3_chk
    import wma3_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // reset leaves no result pending and the input open
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("bad state after reset");

    // one request in flight: busy right after acceptance
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one in work");

    // a result cannot appear the cycle after a request is taken
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind weighted_moving_average_3axis_core wma3_chk u_wma3_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
